/* sv/vsm_pkg.sv */
`timescale 1ns / 1ps

package vsm_pkg;

    localparam int VOICES       = 16;
    localparam int LENGTH_BITS  = 20;
    localparam int VIDX_W       = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int UNITY_SHIFT  = 7;
    localparam int PROD_W       = 25;

    localparam logic signed [31:0] CLAMP_HI = 32'sh003F_FF80;
    localparam logic signed [31:0] CLAMP_LO = -32'sh003F_FF80;
    localparam logic signed [15:0] OUT_HI   = 16'(CLAMP_HI >>> UNITY_SHIFT);
    localparam logic signed [15:0] OUT_LO   = -16'(CLAMP_HI >>> UNITY_SHIFT);
    localparam logic signed [31:0] ROUND_BIAS = 32'((1 << UNITY_SHIFT) - 1);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_MIX   = 1'b1;

    localparam logic REPLY_START = 1'b0;
    localparam logic REPLY_MIX   = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic [LENGTH_BITS-1:0]  len_words;
        logic [7:0]              volume;
        logic                    in_range;
        logic [VIDX_W-1:0]       voice;
        logic signed [15:0]      sample;
        logic                    last;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ACC,
        BK_EMIT
    } t_back_state;

endpackage

/* sv/vsm_front.sv */
`timescale 1ns / 1ps

module vsm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_command,
    input  logic [20:0]         i_length_bytes,
    input  logic [7:0]          i_volume,
    input  logic [3:0]          i_voice_index,
    input  logic signed [15:0]  i_sample_value,
    input  logic                i_last_in_frame,
    output logic                o_q_valid,
    input  logic                i_q_ready,
    output vsm_pkg::t_cmd       o_q_item
);

    logic           r_valid;
    vsm_pkg::t_cmd  r_item;
    vsm_pkg::t_cmd  n_item;
    logic [31:0]    words_ext;
    logic [31:0]    voice_ext;

    always_comb begin
        words_ext        = 32'(i_length_bytes >> 1);
        voice_ext        = 32'(i_voice_index);
        n_item.kind      = i_command;
        n_item.len_words = words_ext[vsm_pkg::LENGTH_BITS-1:0];
        n_item.volume    = i_volume;
        n_item.in_range  = (voice_ext < 32'(vsm_pkg::VOICES));
        n_item.voice     = voice_ext[vsm_pkg::VIDX_W-1:0];
        n_item.sample    = i_sample_value;
        n_item.last      = i_last_in_frame;
    end

    assign o_ready   = !r_valid || i_q_ready;
    assign o_q_valid = r_valid;
    assign o_q_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

/* sv/vsm_fifo.sv */
`timescale 1ns / 1ps

module vsm_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  vsm_pkg::t_cmd   i_push_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output vsm_pkg::t_cmd   o_pop_item
);

    vsm_pkg::t_cmd                  r_mem [vsm_pkg::QUEUE_DEPTH];
    logic [vsm_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [vsm_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [vsm_pkg::QCNT_W-1:0]     r_count;
    logic                           push;
    logic                           pop;

    assign o_push_ready = (r_count != vsm_pkg::QCNT_W'(vsm_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    function automatic logic [vsm_pkg::QPTR_W-1:0] ptr_inc(input logic [vsm_pkg::QPTR_W-1:0] p);
        if (p == vsm_pkg::QPTR_W'(vsm_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

/* sv/vsm_back.sv */
`timescale 1ns / 1ps

module vsm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_data,
    input  logic                i_q_valid,
    output logic                o_q_ready,
    input  vsm_pkg::t_cmd       i_q_item,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_reply_kind,
    output logic [3:0]          o_slot,
    output logic                o_accepted,
    output logic signed [15:0]  o_mixed_sample,
    output logic                o_clipped
);

    logic [vsm_pkg::LENGTH_BITS-1:0] r_len  [vsm_pkg::VOICES];
    logic [vsm_pkg::LENGTH_BITS-1:0] r_pos  [vsm_pkg::VOICES];
    logic [7:0]                 r_gain [vsm_pkg::VOICES];
    logic [vsm_pkg::VOICES-1:0] r_busy;
    logic                       r_enable;

    vsm_pkg::t_back_state       r_state;
    vsm_pkg::t_back_state       n_state;
    logic signed [vsm_pkg::PROD_W-1:0] r_prod;
    logic                       r_last;
    logic signed [31:0]         r_acc;

    logic                       r_out_valid;
    logic                       r_out_kind;
    logic [3:0]                 r_out_slot;
    logic                       r_out_acc;
    logic signed [15:0]         r_out_mix;
    logic                       r_out_clip;

    logic                       out_free;
    logic                       do_start;
    logic                       do_mix;
    logic                       do_emit;

    logic                       found;
    logic [vsm_pkg::VIDX_W-1:0] free_idx;
    logic [31:0]                free_ext;
    logic                       active;
    logic [vsm_pkg::LENGTH_BITS-1:0] pos_inc;
    logic signed [vsm_pkg::PROD_W-1:0] prod;

    logic signed [31:0]         biased;
    logic signed [31:0]         quot;
    logic signed [15:0]         emit_mix;
    logic                       emit_clip;

    // lowest free slot
    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = vsm_pkg::VOICES - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                found    = 1'b1;
                free_idx = vsm_pkg::VIDX_W'(i);
            end
        end
        free_ext = 32'(free_idx);
    end

    always_comb begin
        active  = i_q_item.in_range && r_busy[i_q_item.voice];
        pos_inc = r_pos[i_q_item.voice] + 1'b1;
        prod    = i_q_item.sample * $signed({1'b0, r_gain[i_q_item.voice]});
    end

    // clamp, then divide by unity truncating toward zero
    always_comb begin
        biased    = (r_acc < 0) ? (r_acc + vsm_pkg::ROUND_BIAS) : r_acc;
        quot      = biased >>> vsm_pkg::UNITY_SHIFT;
        emit_clip = 1'b0;
        emit_mix  = quot[15:0];
        if (r_acc > vsm_pkg::CLAMP_HI) begin
            emit_clip = 1'b1;
            emit_mix  = vsm_pkg::OUT_HI;
        end else if (r_acc < vsm_pkg::CLAMP_LO) begin
            emit_clip = 1'b1;
            emit_mix  = vsm_pkg::OUT_LO;
        end
    end

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state   = r_state;
        o_q_ready = 1'b0;
        do_start  = 1'b0;
        do_mix    = 1'b0;
        do_emit   = 1'b0;
        case (r_state)
            vsm_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.kind == vsm_pkg::CMD_START) begin
                        if (out_free) begin
                            o_q_ready = 1'b1;
                            do_start  = 1'b1;
                        end
                    end else begin
                        o_q_ready = 1'b1;
                        do_mix    = 1'b1;
                        n_state   = vsm_pkg::BK_ACC;
                    end
                end
            end
            vsm_pkg::BK_ACC: begin
                n_state = r_last ? vsm_pkg::BK_EMIT : vsm_pkg::BK_IDLE;
            end
            vsm_pkg::BK_EMIT: begin
                if (out_free) begin
                    do_emit = 1'b1;
                    n_state = vsm_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = vsm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vsm_pkg::BK_IDLE;
            r_enable    <= 1'b1;
            r_busy      <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_enable <= i_cfg_data;
            end
            if (do_start && r_enable && found) begin
                r_busy[free_idx] <= (i_q_item.len_words != '0);
            end
            if (do_mix && active && (pos_inc == r_len[i_q_item.voice])) begin
                r_busy[i_q_item.voice] <= 1'b0;
            end
            if (r_state == vsm_pkg::BK_ACC) begin
                r_acc <= r_acc + 32'(r_prod);
            end else if (do_emit) begin
                r_acc <= '0;
            end
            if (do_start || do_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_start && r_enable && found) begin
            r_len[free_idx]  <= i_q_item.len_words;
            r_pos[free_idx]  <= '0;
            r_gain[free_idx] <= i_q_item.volume;
        end
        if (do_mix) begin
            r_last <= i_q_item.last;
            r_prod <= active ? prod : '0;
            if (active) begin
                r_pos[i_q_item.voice] <= pos_inc;
            end
        end
        if (do_start) begin
            r_out_kind <= vsm_pkg::REPLY_START;
            r_out_slot <= (r_enable && found) ? free_ext[3:0] : 4'd0;
            r_out_acc  <= r_enable && found;
            r_out_mix  <= '0;
            r_out_clip <= 1'b0;
        end else if (do_emit) begin
            r_out_kind <= vsm_pkg::REPLY_MIX;
            r_out_slot <= 4'd0;
            r_out_acc  <= 1'b0;
            r_out_mix  <= emit_mix;
            r_out_clip <= emit_clip;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_reply_kind   = r_out_kind;
    assign o_slot         = r_out_slot;
    assign o_accepted     = r_out_acc;
    assign o_mixed_sample = r_out_mix;
    assign o_clipped      = r_out_clip;

endmodule

/* sv/voice_slot_mixer_with_clipping.sv */
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// input     i_valid / o_ready          i_command .. i_last_in_frame
// output    o_valid / i_ready          o_reply_kind .. o_clipped
// config    i_cfg_valid / o_cfg_ready  i_cfg_data (sound enable)
//
// Start items are served in idle, mix items go on to accumulate, a frame's last
// mix item on to emit (clamp and scale); the back end handles one item at a time.
// Input register plus 2-entry queue decouple acceptance from the back end.
// Synchronous active-low reset; all slots free at once, no clearing pass.
// Output register holds a result while the back end goes on with mix items.

module voice_slot_mixer_with_clipping (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_command,
    input  logic [20:0]         i_length_bytes,
    input  logic [7:0]          i_volume,
    input  logic [3:0]          i_voice_index,
    input  logic signed [15:0]  i_sample_value,
    input  logic                i_last_in_frame,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_reply_kind,
    output logic [3:0]          o_slot,
    output logic                o_accepted,
    output logic signed [15:0]  o_mixed_sample,
    output logic                o_clipped,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    logic           f_valid;
    logic           f_ready;
    vsm_pkg::t_cmd  f_item;
    logic           q_valid;
    logic           q_ready;
    vsm_pkg::t_cmd  q_item;

    assign o_cfg_ready = 1'b1;

    vsm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_length_bytes  (i_length_bytes),
        .i_volume        (i_volume),
        .i_voice_index   (i_voice_index),
        .i_sample_value  (i_sample_value),
        .i_last_in_frame (i_last_in_frame),
        .o_q_valid       (f_valid),
        .i_q_ready       (f_ready),
        .o_q_item        (f_item)
    );

    vsm_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_item  (f_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_item   (q_item)
    );

    vsm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (q_valid),
        .o_q_ready      (q_ready),
        .i_q_item       (q_item),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_reply_kind   (o_reply_kind),
        .o_slot         (o_slot),
        .o_accepted     (o_accepted),
        .o_mixed_sample (o_mixed_sample),
        .o_clipped      (o_clipped)
    );

endmodule

/* sv/vsm_checker.sv */
`timescale 1ns / 1ps

module vsm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_ready,
    input logic                o_reply_kind,
    input logic [3:0]          o_slot,
    input logic                o_accepted,
    input logic signed [15:0]  o_mixed_sample,
    input logic                o_clipped
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_mixed_sample) && $stable(o_slot))
        else $error("result dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown after reset");

    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_reply_kind == vsm_pkg::REPLY_START) |->
            (o_mixed_sample == 16'sd0) && !o_clipped)
        else $error("start reply carries mix fields");

    a_refused_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |-> (o_slot == 4'd0))
        else $error("refused or mix reply with nonzero slot");

    a_clip_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |->
            (o_mixed_sample == vsm_pkg::OUT_HI) || (o_mixed_sample == vsm_pkg::OUT_LO))
        else $error("clipped sample not at a limit");

endmodule

bind voice_slot_mixer_with_clipping vsm_checker u_vsm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_reply_kind   (o_reply_kind),
    .o_slot         (o_slot),
    .o_accepted     (o_accepted),
    .o_mixed_sample (o_mixed_sample),
    .o_clipped      (o_clipped)
);
